>>> sv/sve_pkg.sv
// shared types and constants for the 2d shadow volume extruder
// used by the interfaces, the iterative unit and the top level; no dependencies
package sve_pkg;

   // channel field widths
   localparam int TILE_W  = 12;
   localparam int POS_W   = 26;
   localparam int DEPTH_W = 20;
   localparam int SLOT_W  = 10;

   // configuration register widths and indexes
   localparam int LIGHT_W  = 25;
   localparam int RADIUS_W = 19;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;
   localparam logic [1:0] REG_LIGHT_X      = 2'd0;
   localparam logic [1:0] REG_LIGHT_Y      = 2'd1;
   localparam logic [1:0] REG_LIGHT_RADIUS = 2'd2;

   // shared unit operand widths and iteration counts
   localparam int UNIT_AW    = 64;
   localparam int UNIT_BW    = 32;
   localparam int DIVIDEND_W = 48;
   localparam int MUL_ITER   = 32;
   localparam int DIV_ITER   = 48;
   localparam int SQRT_ITER  = 32;
   localparam int ITER_W     = 6;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [UNIT_AW-1:0]   a;
      logic [UNIT_BW-1:0]   b;
   } unit_req_type;

endpackage

>>> sv/sve_if.sv
// request and response channel interfaces of the shadow volume extruder
// depends on sve_pkg for the field widths
interface sve_req_if;
   import sve_pkg::*;
   logic              valid;
   logic              ready;
   logic [TILE_W-1:0] seg_start_x;
   logic [TILE_W-1:0] seg_start_y;
   logic [TILE_W-1:0] seg_end_x;
   logic [TILE_W-1:0] seg_end_y;
   logic              new_light;

   modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, new_light,
                   input ready);
   modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, new_light,
                 output ready);
endinterface

interface sve_rsp_if;
   import sve_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [POS_W-1:0]   vertex_x;
   logic signed [POS_W-1:0]   vertex_y;
   logic [DEPTH_W-1:0]        vertex_depth;
   logic [SLOT_W-1:0]         vertex_slot;
   logic                      last_vertex;

   modport source (output valid, vertex_x, vertex_y, vertex_depth, vertex_slot, last_vertex,
                   input ready);
   modport sink (input valid, vertex_x, vertex_y, vertex_depth, vertex_slot, last_vertex,
                 output ready);
endinterface

>>> sv/shadow_volume_extrude_2d_top.sv
// top level of the 2d shadow volume extruder: sequencer, working registers, csr port
// depends on sve_pkg, sve_if and sve_iter_unit
//
//   channel   direction  handshake            carries
//   req       in         valid/ready          one wall segment and new_light
//   rsp       out        valid/ready          one shadow vertex
//   csr       in/out     apb, pready tied 1   light_x, light_y, light_radius
//
// a drawn segment takes 23 multiplies, 7 square roots and 6 divides, all on the one
// shared unit, then 9 output vertices
// culled segments end after 5 operations (reach test) or 7 (facing test); over the
// shadow limit an item ends in the cycle it is accepted
// reset clears control state and the light registers; no clearing pass
// rsp stalls hold the pending vertex and pause output; the next item can be taken while the last vertex waits
module shadow_volume_extrude_2d_top #(
   parameter int MAX_SHADOWS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   sve_req_if.sink                        req,
   sve_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sve_pkg::CSR_AW-1:0]     paddr,
   input  logic [sve_pkg::CSR_DW-1:0]     pwdata,
   output logic [sve_pkg::CSR_DW-1:0]     prdata,
   output logic                           pready
);
   import sve_pkg::*;

   localparam int CW   = $clog2(MAX_SHADOWS + 1);
   localparam int VW   = 28;   // signed working width of positions
   localparam int SW   = 53;   // sums of two squares
   localparam int DW   = 18;   // q.16 unit vector components
   localparam int LW   = 27;   // vector lengths
   localparam int R2W  = 2 * RADIUS_W;
   localparam int FRAC = 16;
   localparam int DEPTH_MAX = 524288;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic [5:0] {
      S_R2, S_Q0X, S_Q0Y, S_Q1X, S_Q1Y, S_DOTA, S_DOTB,
      S_L0, S_D0X, S_D0Y, S_L1, S_D1X, S_D1Y,
      S_SAX, S_SAY, S_LA, S_AX, S_AY,
      S_C0X, S_C0Y, S_C1X, S_C1Y,
      S_GX, S_GY, S_LG, S_EX, S_EY,
      S_H0X, S_H0Y, S_LH0, S_H1X, S_H1Y, S_LH1, S_HMX, S_HMY, S_LHM
   } step_type;

   function automatic logic [UNIT_BW-1:0] mag32(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] n;
      n = (v < 0) ? -v : v;
      return UNIT_BW'(n);
   endfunction

   // halve, rounding toward zero
   function automatic logic signed [VW-1:0] half_tz(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] t;
      t = v + ((v < 0) ? VW'(1) : VW'(0));
      return t >>> 1;
   endfunction

   function automatic logic [DEPTH_W-1:0] clamp_depth(input logic signed [VW-1:0] d);
      if (d < 0) begin
         return '0;
      end else if (d > VW'(DEPTH_MAX)) begin
         return DEPTH_W'(DEPTH_MAX);
      end
      return DEPTH_W'(d);
   endfunction

   state_type                  state_ff, state_in;
   step_type                   step_ff, step_in;
   logic [3:0]                 corner_ff, corner_in;
   logic [CW-1:0]              count_ff, count_in;
   logic signed [LIGHT_W-1:0]  light_x_ff, light_x_in;
   logic signed [LIGHT_W-1:0]  light_y_ff, light_y_in;
   logic [RADIUS_W-1:0]        light_radius_ff, light_radius_in;
   logic [TILE_W-1:0]          sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [R2W-1:0]             r2_ff, r2_in;
   logic [SW-1:0]              sum_ff, sum_in, q0_ff, q0_in, q1_ff, q1_in;
   logic signed [SW-1:0]       dot_ff, dot_in;
   logic [LW-1:0]              len_ff, len_in, lg_ff, lg_in;
   logic [LW-1:0]              h0_ff, h0_in, h1_ff, h1_in, hm_ff, hm_in;
   logic signed [DW-1:0]       d0x_ff, d0x_in, d0y_ff, d0y_in, d1x_ff, d1x_in, d1y_ff, d1y_in;
   logic signed [DW-1:0]       ax_ff, ax_in, ay_ff, ay_in;
   logic signed [VW-1:0]       c0x_ff, c0x_in, c0y_ff, c0y_in, c1x_ff, c1x_in, c1y_ff, c1y_in;
   logic signed [VW-1:0]       tx_ff, tx_in, ty_ff, ty_in;
   logic                       out_valid_ff, out_valid_in;
   logic signed [POS_W-1:0]    out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [DEPTH_W-1:0]         out_d_ff, out_d_in;
   logic [SLOT_W-1:0]          out_slot_ff, out_slot_in;
   logic                       out_last_ff, out_last_in;

   unit_req_type               ureq;
   logic                       ustart, udone;
   logic [UNIT_AW-1:0]         ures;
   logic                       neg;

   logic signed [VW-1:0] p0x, p0y, p1x, p1y, lx, ly, r_s;
   logic signed [VW-1:0] v0x, v0y, v1x, v1y, fsx, fsy, fex, fey, sadx, sady;
   logic signed [VW-1:0] mx, my, cmx, cmy, extra, e0x, e0y, e1x, e1y, emx, emy;
   logic signed [VW-1:0] sel_x, sel_y, sel_d, mq;
   logic signed [SW-1:0] term;
   logic signed [DW-1:0] div_q;
   logic [SW-1:0]        sq_sum;
   logic [SLOT_W-1:0]    cnt_slot;
   logic [CW-1:0]        count_eff;
   logic                 load, wr_en;

   sve_iter_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .start  (ustart),
      .req    (ureq),
      .done   (udone),
      .result (ures)
   );

   // positions in q.8 pixels: tile * 16 * 256
   assign p0x = $signed(VW'({sx_ff, 12'b0}));
   assign p0y = $signed(VW'({sy_ff, 12'b0}));
   assign p1x = $signed(VW'({ex_ff, 12'b0}));
   assign p1y = $signed(VW'({ey_ff, 12'b0}));
   assign lx  = VW'(light_x_ff);
   assign ly  = VW'(light_y_ff);
   assign r_s = $signed(VW'(light_radius_ff));

   assign v0x  = p0x - lx;
   assign v0y  = p0y - ly;
   assign v1x  = p1x - lx;
   assign v1y  = p1y - ly;
   assign fsx  = p0x + p1x - lx - lx;
   assign fsy  = p0y + p1y - ly - ly;
   assign fex  = p1x - p0x;
   assign fey  = p1y - p0y;
   assign sadx = VW'(d0x_ff) + VW'(d1x_ff);
   assign sady = VW'(d0y_ff) + VW'(d1y_ff);
   assign mx   = (p0x + p1x) >>> 1;
   assign my   = (p0y + p1y) >>> 1;
   assign cmx  = half_tz(c0x_ff + c1x_ff);
   assign cmy  = half_tz(c0y_ff + c1y_ff);
   assign extra = r_s - $signed(VW'(lg_ff));
   assign e0x  = c0x_ff + tx_ff;
   assign e0y  = c0y_ff + ty_ff;
   assign e1x  = c1x_ff + tx_ff;
   assign e1y  = c1y_ff + ty_ff;
   assign emx  = half_tz(e0x + e1x);
   assign emy  = half_tz(e0y + e1y);

   assign ustart = (state_ff == ST_ISSUE);

   // operand selection for the current step
   always_comb begin
      ureq.op = OP_MUL;
      ureq.a  = '0;
      ureq.b  = '0;
      neg     = 1'b0;
      case (step_ff)
         S_R2: begin
            ureq.a = UNIT_AW'(light_radius_ff);
            ureq.b = UNIT_BW'(light_radius_ff);
         end
         S_Q0X: begin ureq.a = UNIT_AW'(mag32(v0x)); ureq.b = mag32(v0x); end
         S_Q0Y: begin ureq.a = UNIT_AW'(mag32(v0y)); ureq.b = mag32(v0y); end
         S_Q1X: begin ureq.a = UNIT_AW'(mag32(v1x)); ureq.b = mag32(v1x); end
         S_Q1Y: begin ureq.a = UNIT_AW'(mag32(v1y)); ureq.b = mag32(v1y); end
         S_DOTA: begin
            // first term is sx * -(ey)
            ureq.a = UNIT_AW'(mag32(fsx));
            ureq.b = mag32(fey);
            neg    = (fsx < 0) ^ (fey > 0);
         end
         S_DOTB: begin
            ureq.a = UNIT_AW'(mag32(fsy));
            ureq.b = mag32(fex);
            neg    = (fsy < 0) ^ (fex < 0);
         end
         S_L0: begin ureq.op = OP_SQRT; ureq.a = UNIT_AW'(q0_ff); end
         S_L1: begin ureq.op = OP_SQRT; ureq.a = UNIT_AW'(q1_ff); end
         S_LA, S_LG, S_LH0, S_LH1, S_LHM: begin
            ureq.op = OP_SQRT;
            ureq.a  = UNIT_AW'(sum_ff);
         end
         S_D0X: begin
            ureq.op = OP_DIV; ureq.a = UNIT_AW'(mag32(v0x)) << FRAC;
            ureq.b = UNIT_BW'(len_ff); neg = (v0x < 0);
         end
         S_D0Y: begin
            ureq.op = OP_DIV; ureq.a = UNIT_AW'(mag32(v0y)) << FRAC;
            ureq.b = UNIT_BW'(len_ff); neg = (v0y < 0);
         end
         S_D1X: begin
            ureq.op = OP_DIV; ureq.a = UNIT_AW'(mag32(v1x)) << FRAC;
            ureq.b = UNIT_BW'(len_ff); neg = (v1x < 0);
         end
         S_D1Y: begin
            ureq.op = OP_DIV; ureq.a = UNIT_AW'(mag32(v1y)) << FRAC;
            ureq.b = UNIT_BW'(len_ff); neg = (v1y < 0);
         end
         S_SAX: begin ureq.a = UNIT_AW'(mag32(sadx)); ureq.b = mag32(sadx); end
         S_SAY: begin ureq.a = UNIT_AW'(mag32(sady)); ureq.b = mag32(sady); end
         S_AX: begin
            ureq.op = OP_DIV; ureq.a = UNIT_AW'(mag32(sadx)) << FRAC;
            ureq.b = UNIT_BW'(len_ff); neg = (sadx < 0);
         end
         S_AY: begin
            ureq.op = OP_DIV; ureq.a = UNIT_AW'(mag32(sady)) << FRAC;
            ureq.b = UNIT_BW'(len_ff); neg = (sady < 0);
         end
         S_C0X: begin
            ureq.a = UNIT_AW'(mag32(VW'(d0x_ff))); ureq.b = UNIT_BW'(light_radius_ff);
            neg = (d0x_ff < 0);
         end
         S_C0Y: begin
            ureq.a = UNIT_AW'(mag32(VW'(d0y_ff))); ureq.b = UNIT_BW'(light_radius_ff);
            neg = (d0y_ff < 0);
         end
         S_C1X: begin
            ureq.a = UNIT_AW'(mag32(VW'(d1x_ff))); ureq.b = UNIT_BW'(light_radius_ff);
            neg = (d1x_ff < 0);
         end
         S_C1Y: begin
            ureq.a = UNIT_AW'(mag32(VW'(d1y_ff))); ureq.b = UNIT_BW'(light_radius_ff);
            neg = (d1y_ff < 0);
         end
         S_GX: begin ureq.a = UNIT_AW'(mag32(cmx - mx)); ureq.b = mag32(cmx - mx); end
         S_GY: begin ureq.a = UNIT_AW'(mag32(cmy - my)); ureq.b = mag32(cmy - my); end
         S_EX: begin
            ureq.a = UNIT_AW'(mag32(VW'(ax_ff))); ureq.b = mag32(extra);
            neg = (ax_ff < 0) ^ (extra < 0);
         end
         S_EY: begin
            ureq.a = UNIT_AW'(mag32(VW'(ay_ff))); ureq.b = mag32(extra);
            neg = (ay_ff < 0) ^ (extra < 0);
         end
         S_H0X: begin ureq.a = UNIT_AW'(mag32(e0x - p0x)); ureq.b = mag32(e0x - p0x); end
         S_H0Y: begin ureq.a = UNIT_AW'(mag32(e0y - p0y)); ureq.b = mag32(e0y - p0y); end
         S_H1X: begin ureq.a = UNIT_AW'(mag32(e1x - p1x)); ureq.b = mag32(e1x - p1x); end
         S_H1Y: begin ureq.a = UNIT_AW'(mag32(e1y - p1y)); ureq.b = mag32(e1y - p1y); end
         S_HMX: begin ureq.a = UNIT_AW'(mag32(emx - mx)); ureq.b = mag32(emx - mx); end
         S_HMY: begin ureq.a = UNIT_AW'(mag32(emy - my)); ureq.b = mag32(emy - my); end
         default: ureq.op = OP_MUL;
      endcase
   end

   // result views
   assign sq_sum = sum_ff + SW'(ures);
   assign term   = neg ? -$signed(SW'(ures)) : $signed(SW'(ures));
   assign mq     = neg ? -$signed(VW'(ures >> FRAC)) : $signed(VW'(ures >> FRAC));
   // a zero length means a zero vector, whose unit vector is zero
   assign div_q  = (len_ff == '0) ? '0 :
                   (neg ? -$signed(DW'(ures)) : $signed(DW'(ures)));

   // corner selection for output
   always_comb begin
      case (corner_ff)
         4'd0:    begin sel_x = p0x;    sel_y = p0y;    sel_d = '0; end
         4'd1:    begin sel_x = mx;     sel_y = my;     sel_d = '0; end
         4'd2:    begin sel_x = p1x;    sel_y = p1y;    sel_d = '0; end
         4'd3:    begin sel_x = c0x_ff; sel_y = c0y_ff; sel_d = r_s; end
         4'd4:    begin sel_x = cmx;    sel_y = cmy;    sel_d = $signed(VW'(lg_ff)); end
         4'd5:    begin sel_x = c1x_ff; sel_y = c1y_ff; sel_d = r_s; end
         4'd6:    begin sel_x = e0x;    sel_y = e0y;    sel_d = $signed(VW'(h0_ff)); end
         4'd7:    begin sel_x = emx;    sel_y = emy;    sel_d = $signed(VW'(hm_ff)); end
         4'd8:    begin sel_x = e1x;    sel_y = e1y;    sel_d = $signed(VW'(h1_ff)); end
         default: begin sel_x = p0x;    sel_y = p0y;    sel_d = '0; end
      endcase
   end

   assign cnt_slot  = SLOT_W'(count_ff);
   assign count_eff = req.new_light ? '0 : count_ff;
   assign load      = !out_valid_ff || rsp.ready;
   assign wr_en     = psel && penable && pwrite;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      corner_in = corner_ff;
      count_in  = count_ff;
      sx_in = sx_ff; sy_in = sy_ff; ex_in = ex_ff; ey_in = ey_ff;
      r2_in = r2_ff; sum_in = sum_ff; q0_in = q0_ff; q1_in = q1_ff; dot_in = dot_ff;
      len_in = len_ff; lg_in = lg_ff; h0_in = h0_ff; h1_in = h1_ff; hm_in = hm_ff;
      d0x_in = d0x_ff; d0y_in = d0y_ff; d1x_in = d1x_ff; d1y_in = d1y_ff;
      ax_in = ax_ff; ay_in = ay_ff;
      c0x_in = c0x_ff; c0y_in = c0y_ff; c1x_in = c1x_ff; c1y_in = c1y_ff;
      tx_in = tx_ff; ty_in = ty_ff;
      out_valid_in = out_valid_ff;
      out_x_in = out_x_ff; out_y_in = out_y_ff; out_d_in = out_d_ff;
      out_slot_in = out_slot_ff; out_last_in = out_last_ff;
      light_x_in = light_x_ff; light_y_in = light_y_ff; light_radius_in = light_radius_ff;

      if (wr_en) begin
         case (paddr[3:2])
            REG_LIGHT_X:      light_x_in      = pwdata[LIGHT_W-1:0];
            REG_LIGHT_Y:      light_y_in      = pwdata[LIGHT_W-1:0];
            REG_LIGHT_RADIUS: light_radius_in = pwdata[RADIUS_W-1:0];
            default:          light_x_in      = light_x_ff;
         endcase
      end

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               sx_in = req.seg_start_x;
               sy_in = req.seg_start_y;
               ex_in = req.seg_end_x;
               ey_in = req.seg_end_y;
               count_in = count_eff;
               step_in  = S_R2;
               if (count_eff < CW'(MAX_SHADOWS)) begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (udone) begin
               state_in = ST_ISSUE;
               step_in  = step_type'(step_ff + 1'b1);
               case (step_ff)
                  S_R2: r2_in = R2W'(ures);
                  S_Q0X, S_Q1X, S_SAX, S_GX, S_H0X, S_H1X, S_HMX: sum_in = SW'(ures);
                  S_Q0Y: q0_in = sq_sum;
                  S_Q1Y: begin
                     q1_in = sq_sum;
                     // neither endpoint within reach
                     if (q0_ff > SW'(r2_ff) && sq_sum > SW'(r2_ff)) begin
                        state_in = ST_IDLE;
                     end
                  end
                  S_SAY, S_GY, S_H0Y, S_H1Y, S_HMY: sum_in = sq_sum;
                  S_DOTA: dot_in = term;
                  S_DOTB: begin
                     dot_in = dot_ff + term;
                     // facing away from the light
                     if (dot_ff + term > 0) begin
                        state_in = ST_IDLE;
                     end
                  end
                  S_L0, S_L1, S_LA: len_in = LW'(ures);
                  S_D0X: d0x_in = div_q;
                  S_D0Y: d0y_in = div_q;
                  S_D1X: d1x_in = div_q;
                  S_D1Y: d1y_in = div_q;
                  S_AX:  ax_in  = div_q;
                  S_AY:  ay_in  = div_q;
                  S_C0X: c0x_in = p0x + mq;
                  S_C0Y: c0y_in = p0y + mq;
                  S_C1X: c1x_in = p1x + mq;
                  S_C1Y: c1y_in = p1y + mq;
                  S_LG:  lg_in  = LW'(ures);
                  S_EX:  tx_in  = mq;
                  S_EY:  ty_in  = mq;
                  S_LH0: h0_in  = LW'(ures);
                  S_LH1: h1_in  = LW'(ures);
                  S_LHM: begin
                     hm_in     = LW'(ures);
                     state_in  = ST_EMIT;
                     corner_in = '0;
                  end
                  default: sum_in = sum_ff;
               endcase
            end
         end
         ST_EMIT: begin
            if (load) begin
               out_valid_in = 1'b1;
               out_x_in     = POS_W'(sel_x);
               out_y_in     = POS_W'(sel_y);
               out_d_in     = clamp_depth(sel_d);
               out_slot_in  = SLOT_W'({cnt_slot, 3'b000} + cnt_slot + corner_ff);
               out_last_in  = (corner_ff == 4'd8);
               corner_in    = corner_ff + 1'b1;
               if (corner_ff == 4'd8) begin
                  state_in = ST_IDLE;
                  count_in = CW'(count_ff + 1'b1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= S_R2;
         corner_ff       <= '0;
         count_ff        <= '0;
         out_valid_ff    <= 1'b0;
         light_x_ff      <= '0;
         light_y_ff      <= '0;
         light_radius_ff <= '0;
      end else begin
         state_ff        <= state_in;
         step_ff         <= step_in;
         corner_ff       <= corner_in;
         count_ff        <= count_in;
         out_valid_ff    <= out_valid_in;
         light_x_ff      <= light_x_in;
         light_y_ff      <= light_y_in;
         light_radius_ff <= light_radius_in;
      end
      sx_ff <= sx_in; sy_ff <= sy_in; ex_ff <= ex_in; ey_ff <= ey_in;
      r2_ff <= r2_in; sum_ff <= sum_in; q0_ff <= q0_in; q1_ff <= q1_in; dot_ff <= dot_in;
      len_ff <= len_in; lg_ff <= lg_in; h0_ff <= h0_in; h1_ff <= h1_in; hm_ff <= hm_in;
      d0x_ff <= d0x_in; d0y_ff <= d0y_in; d1x_ff <= d1x_in; d1y_ff <= d1y_in;
      ax_ff <= ax_in; ay_ff <= ay_in;
      c0x_ff <= c0x_in; c0y_ff <= c0y_in; c1x_ff <= c1x_in; c1y_ff <= c1y_in;
      tx_ff <= tx_in; ty_ff <= ty_in;
      out_x_ff <= out_x_in; out_y_ff <= out_y_in; out_d_ff <= out_d_in;
      out_slot_ff <= out_slot_in; out_last_ff <= out_last_in;
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = out_valid_ff;
   assign rsp.vertex_x     = out_x_ff;
   assign rsp.vertex_y     = out_y_ff;
   assign rsp.vertex_depth = out_d_ff;
   assign rsp.vertex_slot  = out_slot_ff;
   assign rsp.last_vertex  = out_last_ff;

   assign pready = 1'b1;
   always_comb begin
      case (paddr[3:2])
         REG_LIGHT_X:      prdata = CSR_DW'(unsigned'(light_x_ff));
         REG_LIGHT_Y:      prdata = CSR_DW'(unsigned'(light_y_ff));
         REG_LIGHT_RADIUS: prdata = CSR_DW'(light_radius_ff);
         default:          prdata = '0;
      endcase
   end

endmodule

>>> sv/sve_iter_unit.sv
// shared iterative unit: shift-add multiply, restoring divide, bit-pair square root
// one bit or one bit pair per cycle; depends on sve_pkg
module sve_iter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  sve_pkg::unit_req_type         req,
   output logic                          done,
   output logic [sve_pkg::UNIT_AW-1:0]   result
);
   import sve_pkg::*;

   typedef enum logic [1:0] {
      U_IDLE,
      U_BUSY,
      U_DONE
   } ustate_type;

   ustate_type           state_ff, state_in;
   op_type               op_ff, op_in;
   logic [ITER_W-1:0]    cnt_ff, cnt_in;
   logic [UNIT_AW-1:0]   acc_ff, acc_in;
   logic [UNIT_AW-1:0]   opa_ff, opa_in;
   logic [UNIT_BW-1:0]   opb_ff, opb_in;

   logic [UNIT_BW:0]     div_sh;
   logic [UNIT_BW+2:0]   sq_sh;
   logic [UNIT_BW+2:0]   sq_trial;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      div_sh   = {acc_ff[UNIT_BW-1:0], opa_ff[DIVIDEND_W-1]};
      sq_sh    = {acc_ff[UNIT_BW:0], opa_ff[UNIT_AW-1 -: 2]};
      sq_trial = {1'b0, opb_ff, 2'b01};
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               state_in = U_BUSY;
               op_in    = req.op;
               acc_in   = '0;
               opb_in   = req.b;
               opa_in   = req.a;
               case (req.op)
                  OP_MUL:  cnt_in = ITER_W'(MUL_ITER - 1);
                  OP_DIV: begin
                     cnt_in = ITER_W'(DIV_ITER - 1);
                     opa_in = UNIT_AW'(req.a[DIVIDEND_W-1:0]);
                  end
                  OP_SQRT: begin
                     cnt_in = ITER_W'(SQRT_ITER - 1);
                     opb_in = '0;
                  end
                  default: cnt_in = ITER_W'(MUL_ITER - 1);
               endcase
            end
         end
         U_BUSY: begin
            case (op_ff)
               OP_MUL: begin
                  if (opb_ff[0]) begin
                     acc_in = acc_ff + opa_ff;
                  end
                  opa_in = {opa_ff[UNIT_AW-2:0], 1'b0};
                  opb_in = {1'b0, opb_ff[UNIT_BW-1:1]};
               end
               OP_DIV: begin
                  if (div_sh >= {1'b0, opb_ff}) begin
                     acc_in = UNIT_AW'(div_sh - {1'b0, opb_ff});
                     opa_in = UNIT_AW'({opa_ff[DIVIDEND_W-2:0], 1'b1});
                  end else begin
                     acc_in = UNIT_AW'(div_sh);
                     opa_in = UNIT_AW'({opa_ff[DIVIDEND_W-2:0], 1'b0});
                  end
               end
               OP_SQRT: begin
                  if (sq_sh >= sq_trial) begin
                     acc_in = UNIT_AW'(sq_sh - sq_trial);
                     opb_in = {opb_ff[UNIT_BW-2:0], 1'b1};
                  end else begin
                     acc_in = UNIT_AW'(sq_sh);
                     opb_in = {opb_ff[UNIT_BW-2:0], 1'b0};
                  end
                  opa_in = {opa_ff[UNIT_AW-3:0], 2'b00};
               end
               default: acc_in = acc_ff;
            endcase
            if (cnt_ff == '0) begin
               state_in = U_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         U_DONE:  state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
   end

   assign done = (state_ff == U_DONE);

   always_comb begin
      case (op_ff)
         OP_MUL:  result = acc_ff;
         OP_DIV:  result = UNIT_AW'(opa_ff[DIVIDEND_W-1:0]);
         OP_SQRT: result = UNIT_AW'(opb_ff);
         default: result = acc_ff;
      endcase
   end

endmodule

>>> sv/sve_checker.sv
// port-level checks for the shadow volume extruder, bound to the top level
// depends only on the top level's ports
module sve_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last_vertex
);

   // a pending vertex is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("vertex dropped while stalled");

   // right after reset the block is idle and ready with no vertex pending
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // vertices of one shadow come back to back when taken
   a_vertex_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_vertex |=> rsp_valid)
      else $error("gap inside a shadow");

   // no new item while a shadow is still being sent
   a_no_accept_mid_shadow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_vertex |-> !req_ready)
      else $error("ready high during a shadow");

endmodule

bind shadow_volume_extrude_2d_top sve_checker u_sve_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_last_vertex (rsp.last_vertex)
);
